// ----- hw/rtl/nps_pkg.sv -----
package nps_pkg;

    // Sizes of the point store and of the fields
    localparam int MAX_POINTS  = 1024;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = 34;
    localparam int KIND_W      = 2;
    localparam int POINT_W     = 3 * COORD_W;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // One command as it travels from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_item;

endpackage

// ----- hw/rtl/nps_if.sv -----
// Command channel: load, query or clear beats
interface nps_in_if;
    logic                                valid;
    logic                                ready;
    logic [nps_pkg::KIND_W-1:0]          kind;
    logic signed [nps_pkg::COORD_W-1:0]  coord_x;
    logic signed [nps_pkg::COORD_W-1:0]  coord_y;
    logic signed [nps_pkg::COORD_W-1:0]  coord_z;

    modport source (output valid, kind, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, kind, coord_x, coord_y, coord_z, output ready);
endinterface

// Result channel: one beat per query
interface nps_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [nps_pkg::COORD_W-1:0]  near_x;
    logic signed [nps_pkg::COORD_W-1:0]  near_y;
    logic signed [nps_pkg::COORD_W-1:0]  near_z;
    logic [nps_pkg::IDX_W-1:0]           near_index;
    logic [nps_pkg::DIST_W-1:0]          sq_distance;
    logic                                found;

    modport source (output valid, near_x, near_y, near_z, near_index, sq_distance, found,
                    input ready);
    modport sink   (input valid, near_x, near_y, near_z, near_index, sq_distance, found,
                    output ready);
endinterface

// ----- hw/rtl/nearest_point_search.sv -----
// Brute-force 3-D nearest-point search.
// i_req carries command beats: kind 0 appends a reference point to the
// store (dropped once 1024 points are held), kind 1 is a query, kind 2
// empties the store, kind 3 is accepted and ignored.
// o_rsp carries one beat per query: the closest stored point, its index
// (lowest index on ties), the squared distance with 16 fraction bits, and
// found=0 with all other fields zero when the store is empty.
// Commands enter a two-entry queue, so i_req keeps accepting while the
// search engine works, until the queue fills.
// The engine handles a load or clear as it pops it from the queue. A
// query passes through the queue, reads the N stored points one per cycle
// from the store, squares the differences in a squaring stage, updates
// the running best, leaves the scan and goes into the result register.
// The engine takes no new command until that result is written, so the
// time per query grows with N, set by the single read port of the point
// store. An empty-store query skips the scan.
// Reset (synchronous, active low) empties the store and the queue and
// drops any pending result. While o_rsp is stalled the finished result
// holds; the engine still runs loads and clears but waits to write the
// next result until the register frees.
module nearest_point_search (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nps_in_if.sink    i_req,
    nps_out_if.source o_rsp
);

    logic           cmd_valid;
    nps_pkg::t_item cmd;
    logic           cmd_pop;

    nps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    nps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- hw/rtl/nps_front.sv -----
module nps_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nps_in_if.sink         i_req,
    output logic           o_cmd_valid,
    output nps_pkg::t_item o_cmd,
    input  logic           i_cmd_pop
);

    // Two-entry command queue
    nps_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign i_req.ready = (r_cnt != 2'd2);
    // Unused kind is accepted and dropped here
    assign push = i_req.valid && i_req.ready &&
                  (i_req.kind == nps_pkg::KIND_LOAD  ||
                   i_req.kind == nps_pkg::KIND_QUERY ||
                   i_req.kind == nps_pkg::KIND_CLEAR);
    assign pop  = i_cmd_pop && (r_cnt != 2'd0);

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: i_req.kind, coord_x: i_req.coord_x,
                           coord_y: i_req.coord_y, coord_z: i_req.coord_z};
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- hw/rtl/nps_back.sv -----
module nps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  nps_pkg::t_item i_cmd,
    output logic           o_cmd_pop,
    nps_out_if.source      o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [nps_pkg::CNT_W-1:0]         r_count;
    logic [nps_pkg::POINT_W-1:0]       r_mem [nps_pkg::MAX_POINTS];
    nps_pkg::t_item                    r_query;
    logic [nps_pkg::IDX_W-1:0]         r_addr;
    logic                              r_issue_done;
    logic                              rd_en;
    logic                              wr_en;
    logic                              last_addr;

    // Read pipeline
    logic [nps_pkg::POINT_W-1:0]       r_rd_data;
    logic                              r_v1;
    logic [nps_pkg::IDX_W-1:0]         r_idx1;
    logic signed [nps_pkg::DIFF_W-1:0] dx, dy, dz;
    logic signed [2*nps_pkg::DIFF_W-1:0] px, py, pz;
    logic                              r_v2;
    logic [nps_pkg::IDX_W-1:0]         r_idx2;
    logic [nps_pkg::POINT_W-1:0]       r_pt2;
    logic [nps_pkg::SQ_W-1:0]          r_sqx, r_sqy, r_sqz;
    logic [nps_pkg::DIST_W-1:0]        cand_d;

    // Running best
    logic [nps_pkg::DIST_W-1:0]        r_best_d;
    logic [nps_pkg::IDX_W-1:0]         r_best_i;
    logic [nps_pkg::POINT_W-1:0]       r_best_p;
    logic                              r_found;

    logic                              r_out_valid;
    logic                              out_free;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign wr_en     = o_cmd_pop && (i_cmd.kind == nps_pkg::KIND_LOAD) &&
                       (r_count < nps_pkg::CNT_W'(nps_pkg::MAX_POINTS));
    assign rd_en     = (r_state == S_SCAN) && !r_issue_done;
    assign last_addr = ({1'b0, r_addr} == r_count - nps_pkg::CNT_W'(1));
    assign out_free  = !r_out_valid || o_rsp.ready;

    // Point store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[nps_pkg::IDX_W-1:0]] <= {i_cmd.coord_x, i_cmd.coord_y,
                                                    i_cmd.coord_z};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Stage 1: per-axis difference and square
    always_comb begin
        dx = nps_pkg::DIFF_W'(r_query.coord_x) -
             nps_pkg::DIFF_W'($signed(r_rd_data[3*nps_pkg::COORD_W-1 -: nps_pkg::COORD_W]));
        dy = nps_pkg::DIFF_W'(r_query.coord_y) -
             nps_pkg::DIFF_W'($signed(r_rd_data[2*nps_pkg::COORD_W-1 -: nps_pkg::COORD_W]));
        dz = nps_pkg::DIFF_W'(r_query.coord_z) -
             nps_pkg::DIFF_W'($signed(r_rd_data[nps_pkg::COORD_W-1 -: nps_pkg::COORD_W]));
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_addr;
        r_idx2 <= r_idx1;
        r_pt2  <= r_rd_data;
        r_sqx  <= px[nps_pkg::SQ_W-1:0];
        r_sqy  <= py[nps_pkg::SQ_W-1:0];
        r_sqz  <= pz[nps_pkg::SQ_W-1:0];
    end

    // Stage 2: sum of squares
    assign cand_d = nps_pkg::DIST_W'(r_sqx) + nps_pkg::DIST_W'(r_sqy) +
                    nps_pkg::DIST_W'(r_sqz);

    // Best-so-far tracking; first strict minimum wins
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.kind == nps_pkg::KIND_QUERY) begin
            r_best_d <= '0;
            r_best_i <= '0;
            r_best_p <= '0;
            r_found  <= (r_count != '0);
        end else if (r_v2 && (r_idx2 == '0 || cand_d < r_best_d)) begin
            r_best_d <= cand_d;
            r_best_i <= r_idx2;
            r_best_p <= r_pt2;
        end
    end

    // Query latch
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_query <= i_cmd;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_pop && i_cmd.kind == nps_pkg::KIND_QUERY) begin
                    n_state = (r_count == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_issue_done && !r_v1 && !r_v2) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= rd_en;
            r_v2    <= r_v1;
            if (wr_en) begin
                r_count <= r_count + nps_pkg::CNT_W'(1);
            end else if (o_cmd_pop && i_cmd.kind == nps_pkg::KIND_CLEAR) begin
                r_count <= '0;
            end
            if (o_cmd_pop) begin
                r_addr       <= '0;
                r_issue_done <= 1'b0;
            end else if (rd_en) begin
                if (last_addr) r_issue_done <= 1'b1;
                else           r_addr <= r_addr + nps_pkg::IDX_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_rsp.near_x      <= r_best_p[3*nps_pkg::COORD_W-1 -: nps_pkg::COORD_W];
            o_rsp.near_y      <= r_best_p[2*nps_pkg::COORD_W-1 -: nps_pkg::COORD_W];
            o_rsp.near_z      <= r_best_p[nps_pkg::COORD_W-1 -: nps_pkg::COORD_W];
            o_rsp.near_index  <= r_best_i;
            o_rsp.sq_distance <= r_best_d;
            o_rsp.found       <= r_found;
        end
    end

    assign o_rsp.valid = r_out_valid;

endmodule
